@@ src/gaussian_blur_5x5_rgb_core_assert.svh @@
// Assertion macros for the gaussian blur core checker.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef GAUSSIAN_BLUR_5X5_RGB_CORE_ASSERT_SVH
`define GAUSSIAN_BLUR_5X5_RGB_CORE_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define GBLUR_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gblur check failed: same-cycle implication");

// Next-cycle implication, disabled while in reset
`define GBLUR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gblur check failed: next-cycle implication");

`endif

@@ src/gblur_pkg.sv @@
// Shared constants, types and arithmetic helpers for the 5x5 gaussian blur core.
// No dependencies; imported by the interfaces and the core.
package gblur_pkg;

    localparam int MAX_WIDTH   = 2048;
    localparam int MAX_HEIGHT  = 4096;
    localparam int TAPS        = 5;
    localparam int ROWS_KEPT   = TAPS - 1;

    localparam int CHAN_W      = 8;
    localparam int NUM_CHAN    = 3;
    localparam int PIX_W       = NUM_CHAN * CHAN_W;
    localparam int ROW_WORD_W  = ROWS_KEPT * PIX_W;
    localparam int COL_ADDR_W  = $clog2(MAX_WIDTH);

    localparam int WIDTH_W     = 12;
    localparam int HEIGHT_W    = 13;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_INDEX_W = 1;

    // column sum max 255*16, full sum max 255*256
    localparam int VSUM_W      = 12;
    localparam int HSUM_W      = 16;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 12'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    // weights 1 4 6 4 1 down one column of the window
    function automatic logic [VSUM_W-1:0] vert_sum(
        input logic [CHAN_W-1:0] p0,
        input logic [CHAN_W-1:0] p1,
        input logic [CHAN_W-1:0] p2,
        input logic [CHAN_W-1:0] p3,
        input logic [CHAN_W-1:0] p4
    );
        logic [VSUM_W-1:0] e0, e1, e2, e3, e4;
        e0 = VSUM_W'(p0);
        e1 = VSUM_W'(p1);
        e2 = VSUM_W'(p2);
        e3 = VSUM_W'(p3);
        e4 = VSUM_W'(p4);
        return e0 + (e1 << 2) + (e2 << 2) + (e2 << 1) + (e3 << 2) + e4;
    endfunction

    // weights 1 4 6 4 1 across the five column sums
    function automatic logic [HSUM_W-1:0] horiz_sum(
        input logic [VSUM_W-1:0] s0,
        input logic [VSUM_W-1:0] s1,
        input logic [VSUM_W-1:0] s2,
        input logic [VSUM_W-1:0] s3,
        input logic [VSUM_W-1:0] s4
    );
        logic [HSUM_W-1:0] e0, e1, e2, e3, e4;
        e0 = HSUM_W'(s0);
        e1 = HSUM_W'(s1);
        e2 = HSUM_W'(s2);
        e3 = HSUM_W'(s3);
        e4 = HSUM_W'(s4);
        return e0 + (e1 << 2) + (e2 << 2) + (e2 << 1) + (e3 << 2) + e4;
    endfunction

    // divide by 256, round half to even
    function automatic logic [CHAN_W-1:0] round_half_even(input logic [HSUM_W-1:0] s);
        logic [CHAN_W-1:0]        q;
        logic [HSUM_W-CHAN_W-1:0] r;
        logic                     up;
        q  = s[HSUM_W-1 -: CHAN_W];
        r  = s[HSUM_W-CHAN_W-1:0];
        up = (r > 8'd128) || ((r == 8'd128) && q[0]);
        return q + CHAN_W'(up);
    endfunction

endpackage

@@ src/gblur_if.sv @@
// Valid/ready stream interfaces for pixel words into and out of the blur core.
// Depends on gblur_pkg.
interface gblur_in_if import gblur_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              start_of_frame;
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;

    modport source (
        output valid, start_of_frame, red_in, green_in, blue_in,
        input  ready
    );
    modport sink (
        input  valid, start_of_frame, red_in, green_in, blue_in,
        output ready
    );
endinterface

interface gblur_out_if import gblur_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic              frame_last;

    modport source (
        output valid, red_out, green_out, blue_out, frame_last,
        input  ready
    );
    modport sink (
        input  valid, red_out, green_out, blue_out, frame_last,
        output ready
    );
endinterface

@@ src/gblur_ram.sv @@
// Generic single-write, single-read RAM with registered read data (read-first).
// No dependencies.
module gblur_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ src/gaussian_blur_5x5_rgb_core.sv @@
// Top level of the 5x5 binomial blur for 8-bit RGB pixel streams.
// Depends on gblur_pkg, gblur_if (gblur_in_if, gblur_out_if) and gblur_ram.
//
//  channel   | dir | handshake      | word
//  ----------+-----+----------------+-----------------------------------------------
//  pixels    | in  | valid / ready  | start_of_frame, red_in, green_in, blue_in
//  blurred   | out | valid / ready  | red_out, green_out, blue_out, frame_last
//  cfg       | in  | cfg_write      | cfg_index, cfg_data (frame_width, frame_height)
//
//  One pixel word per clock sustained while the output is not stalled.
//  Stages: input register (line store read), column-sum window, output register.
//  Line store is a 2048 x 96 RAM holding four rows per column; no clearing pass.
//  Reset clears handshake state and position counters, sets geometry to 640 x 480.
//  Input keeps flowing while a result waits, as long as a pipeline stage is free.
module gaussian_blur_5x5_rgb_core import gblur_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    gblur_in_if.sink               pixels,
    gblur_out_if.source            blurred
);

    // geometry registers
    logic [WIDTH_W-1:0]  frame_width_reg;
    logic [HEIGHT_W-1:0] frame_height_reg;

    // position counters
    logic [WIDTH_W-1:0]  col_cnt_reg;
    logic [HEIGHT_W-1:0] row_cnt_reg;

    // input stage
    logic                  a_valid_reg;
    logic [PIX_W-1:0]      a_pix_reg;
    logic [COL_ADDR_W-1:0] a_addr_reg;
    logic                  a_usable_reg;
    logic                  a_emit_reg;
    logic                  a_last_reg;
    logic                  byp_valid_reg;
    logic [ROW_WORD_W-1:0] byp_data_reg;

    // window stage
    logic                  c_valid_reg;
    logic                  c_last_reg;
    logic [VSUM_W-1:0]     line_reg [NUM_CHAN][TAPS];

    // output register
    logic                  o_valid_reg;
    logic [CHAN_W-1:0]     o_red_reg;
    logic [CHAN_W-1:0]     o_green_reg;
    logic [CHAN_W-1:0]     o_blue_reg;
    logic                  o_last_reg;

    logic                  o_en, c_en, a_en, a_adv, accept;
    logic                  geometry_ok;
    logic [WIDTH_W-1:0]    pos_x;
    logic [HEIGHT_W-1:0]   pos_y;
    logic [WIDTH_W:0]      x_inc;
    logic [HEIGHT_W:0]     y_inc;
    logic                  usable_in, emit_in, last_in;
    logic [ROW_WORD_W-1:0] ram_rd_data;
    logic [ROW_WORD_W-1:0] above;
    logic [ROW_WORD_W-1:0] wr_data;
    logic                  wr_en;
    logic [PIX_W-1:0]      col [TAPS];
    logic [VSUM_W-1:0]     vsum [NUM_CHAN];
    logic [CHAN_W-1:0]     result [NUM_CHAN];

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= WIDTH_RESET;
            frame_height_reg <= HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[WIDTH_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[HEIGHT_W-1:0];
                default:          ;
            endcase
        end
    end

    // pipeline enables
    assign o_en         = !o_valid_reg || blurred.ready;
    assign c_en         = !c_valid_reg || o_en;
    assign a_en         = !a_valid_reg || c_en;
    assign a_adv        = a_valid_reg && c_en;
    assign pixels.ready = a_en;
    assign accept       = pixels.valid && a_en;

    // position of the incoming word and its classification
    assign pos_x = pixels.start_of_frame ? '0 : col_cnt_reg;
    assign pos_y = pixels.start_of_frame ? '0 : row_cnt_reg;
    assign x_inc = {1'b0, pos_x} + 1'b1;
    assign y_inc = {1'b0, pos_y} + 1'b1;

    assign geometry_ok = (frame_width_reg  >= WIDTH_W'(TAPS))
                      && (frame_width_reg  <= WIDTH_W'(MAX_WIDTH))
                      && (frame_height_reg >= HEIGHT_W'(TAPS))
                      && (frame_height_reg <= HEIGHT_W'(MAX_HEIGHT));
    assign usable_in = geometry_ok && (pos_x < frame_width_reg) && (pos_y < frame_height_reg);
    assign emit_in   = usable_in && (pos_x >= WIDTH_W'(TAPS - 1))
                                 && (pos_y >= HEIGHT_W'(TAPS - 1));
    assign last_in   = (x_inc == {1'b0, frame_width_reg}) && (y_inc == {1'b0, frame_height_reg});

    // raster position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end
        else if (accept)
        begin
            if (x_inc >= {1'b0, frame_width_reg})
            begin
                col_cnt_reg <= '0;
                row_cnt_reg <= (y_inc >= {1'b0, frame_height_reg}) ? '0 : y_inc[HEIGHT_W-1:0];
            end
            else
            begin
                col_cnt_reg <= x_inc[WIDTH_W-1:0];
                row_cnt_reg <= pos_y;
            end
        end
    end

    // input stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_en)
            begin
                a_valid_reg <= pixels.valid;
            end
            // same column written back as it is read again: forward the write
            if (accept)
            begin
                byp_valid_reg <= wr_en && (pos_x[COL_ADDR_W-1:0] == a_addr_reg);
            end
        end
    end

    // input stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_pix_reg    <= {pixels.blue_in, pixels.green_in, pixels.red_in};
            a_addr_reg   <= pos_x[COL_ADDR_W-1:0];
            a_usable_reg <= usable_in;
            a_emit_reg   <= emit_in;
            a_last_reg   <= last_in;
            byp_data_reg <= wr_data;
        end
    end

    // line store: four older rows of each column in one word
    gblur_ram #(
        .WIDTH (ROW_WORD_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (a_addr_reg),
        .wr_data (wr_data),
        .rd_en   (accept),
        .rd_addr (pos_x[COL_ADDR_W-1:0]),
        .rd_data (ram_rd_data)
    );

    assign above   = byp_valid_reg ? byp_data_reg : ram_rd_data;
    assign wr_en   = a_adv && a_usable_reg;
    assign wr_data = {a_pix_reg, above[ROW_WORD_W-1:PIX_W]};

    // new window column and its weighted sums
    always_comb
    begin
        for (int k = 0; k < ROWS_KEPT; k++)
        begin
            col[k] = above[k*PIX_W +: PIX_W];
        end
        col[TAPS-1] = a_pix_reg;
        for (int ch = 0; ch < NUM_CHAN; ch++)
        begin
            vsum[ch] = vert_sum(col[0][ch*CHAN_W +: CHAN_W], col[1][ch*CHAN_W +: CHAN_W],
                                col[2][ch*CHAN_W +: CHAN_W], col[3][ch*CHAN_W +: CHAN_W],
                                col[4][ch*CHAN_W +: CHAN_W]);
        end
    end

    // window of column sums, shifted on every usable word
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            for (int ch = 0; ch < NUM_CHAN; ch++)
            begin
                for (int t = 0; t < TAPS - 1; t++)
                begin
                    line_reg[ch][t] <= line_reg[ch][t+1];
                end
                line_reg[ch][TAPS-1] <= vsum[ch];
            end
        end
    end

    // window stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (c_en)
        begin
            c_valid_reg <= a_adv && a_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_en)
        begin
            c_last_reg <= a_last_reg;
        end
    end

    // horizontal sum and rounding
    always_comb
    begin
        for (int ch = 0; ch < NUM_CHAN; ch++)
        begin
            result[ch] = round_half_even(horiz_sum(line_reg[ch][0], line_reg[ch][1],
                                                   line_reg[ch][2], line_reg[ch][3],
                                                   line_reg[ch][4]));
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (o_en)
        begin
            o_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (o_en && c_valid_reg)
        begin
            o_red_reg   <= result[0];
            o_green_reg <= result[1];
            o_blue_reg  <= result[2];
            o_last_reg  <= c_last_reg;
        end
    end

    assign blurred.valid      = o_valid_reg;
    assign blurred.red_out    = o_red_reg;
    assign blurred.green_out  = o_green_reg;
    assign blurred.blue_out   = o_blue_reg;
    assign blurred.frame_last = o_last_reg;

endmodule

@@ src/gblur_checker.sv @@
// Port-level checker for the gaussian blur core, bound to the top level.
// Depends on gaussian_blur_5x5_rgb_core_assert.svh.
`include "gaussian_blur_5x5_rgb_core_assert.svh"

module gblur_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] red_out,
    input logic [7:0] green_out,
    input logic [7:0] blue_out,
    input logic       frame_last
);

    // a stalled result word holds still
    `GBLUR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(red_out) && $stable(green_out) && $stable(blue_out) && $stable(frame_last))

    // with the output side free the core always takes a word
    `GBLUR_ASSERT_IMPL(a_ready_when_free, !out_valid || out_ready, in_ready)

    // draining with no new word taken and the output ready empties the input, window and output registers
    `GBLUR_ASSERT_NEXT(a_drain, (!(in_valid && in_ready) && out_ready) ##1 (!(in_valid && in_ready) && out_ready) ##1 (!(in_valid && in_ready) && out_ready), !out_valid)

endmodule

bind gaussian_blur_5x5_rgb_core gblur_checker u_gblur_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (pixels.valid),
    .in_ready   (pixels.ready),
    .out_valid  (blurred.valid),
    .out_ready  (blurred.ready),
    .red_out    (blurred.red_out),
    .green_out  (blurred.green_out),
    .blue_out   (blurred.blue_out),
    .frame_last (blurred.frame_last)
);
